// ===== design/hbcf_pkg.sv =====
// Shared types, register codes and constants for the heterodyne bin centroid feedback core.
`default_nettype none

package hbcf_pkg;

    // Default values for the top level parameters.
    localparam int MAX_BINS_DEF    = 64;
    localparam int PHASE_BITS_DEF  = 16;
    localparam int SAMPLE_BITS_DEF = 14;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_SKIP    = 3'd0,
        REG_STEP    = 3'd1,
        REG_SPB     = 3'd2,
        REG_BINS    = 3'd3,
        REG_BTS     = 3'd4,
        REG_OFFSET  = 3'd5,
        REG_DECAY   = 3'd6,
        REG_GAIN    = 3'd7
    } t_reg_idx;

    // Output rail status codes.
    typedef enum logic [1:0] {
        RAIL_NONE = 2'd0,
        RAIL_HIGH = 2'd1,
        RAIL_LOW  = 2'd2
    } t_rail;

    // Register reset values.
    localparam logic [12:0] SKIP_RST   = 13'd390;
    localparam logic [15:0] STEP_RST   = 16'd8402;
    localparam logic [13:0] SPB_RST    = 14'd195;
    localparam logic [6:0]  BINS_RST   = 7'd40;
    localparam logic [30:0] BTS_RST    = 31'd26800596;
    localparam logic [30:0] OFFSET_RST = 31'd528452776;
    localparam logic [15:0] DECAY_RST  = 16'd45875;
    localparam logic [15:0] GAIN_RST   = 16'd4588;

    localparam logic [13:0] SPB_LIMIT  = 14'd8192;

    // Quarter-wave sine polynomial coefficients.
    localparam logic [15:0] SIN_C1 = 16'd51472;
    localparam logic [14:0] SIN_C3 = 15'd21024;
    localparam logic [11:0] SIN_C5 = 12'd2320;

    // Saturation limits.
    localparam logic signed [40:0] ACC_MAX  = 41'sd549755813887;
    localparam logic signed [40:0] ACC_MIN  = -41'sd549755813888;
    localparam logic signed [51:0] HIST_MAX = 52'sd8589934591;
    localparam logic signed [51:0] HIST_MIN = -52'sd8589934592;
    localparam logic signed [38:0] I32_MAX  = 39'sd2147483647;
    localparam logic signed [38:0] I32_MIN  = -39'sd2147483648;
    localparam logic signed [51:0] ONE_Q30  = 52'sd1073741824;

endpackage

`default_nettype wire

// ===== design/hbcf_in_if.sv =====
// Request channel carrying one ADC sample and its shot start mark.
`default_nettype none

interface hbcf_in_if #(
    parameter int SAMPLE_BITS = 14
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          shot_start;

    modport source (output valid, output sample, output shot_start, input ready);
    modport sink   (input valid, input sample, input shot_start, output ready);
endinterface

`default_nettype wire

// ===== design/hbcf_out_if.sv =====
// Request channel carrying one shot result: center, drive and rail status.
`default_nettype none

interface hbcf_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] center;
    logic signed [31:0] drive;
    logic [1:0]         rail;

    modport source (output valid, output center, output drive, output rail, input ready);
    modport sink   (input valid, input center, input drive, input rail, output ready);
endinterface

`default_nettype wire

// ===== design/heterodyne_bin_centroid_feedback_core.sv =====
// Top level of the heterodyne bin centroid feedback core: sequencer around one shared multiplier.
//
// Usage: samples arrive on the i_in channel, one request per ADC sample. A request with
// shot_start set opens a shot; the sample index, NCO phase and all sums restart with it.
// While no shot is open, samples without shot_start are taken and dropped at once.
// After skip_samples samples, every sample is mixed with cosine and sine and summed into
// bins; after the last bin one request leaves on o_out with center, drive and rail.
// Configuration must be written through i_cfg_we / i_cfg_idx / i_cfg_data only while idle;
// the block itself does not enforce this. A dropped or skipped sample is handled in the idle
// state. A mixed sample passes through the shared multiplier: five products per sine/cosine
// value (the polynomial and the mix) plus one accumulate step each. Closing a bin adds two
// squares and two partial weight products. Closing the shot adds a bit-serial restoring
// divider for the 30-bit centroid quotient, then the scale, history and drive products.
// Only one sample is in work at a time; i_in.ready is high only while the sequencer idles.
// The result sits in an output register. A stalled receiver holds it there while the
// next samples keep being taken; only a second finished result waits for the slot.
// Reset (synchronous, active low) restores the register defaults, clears the control state,
// empties the output register and leaves the block idle until a shot start arrives.
`default_nettype none

module heterodyne_bin_centroid_feedback_core
    import hbcf_pkg::*;
#(
    parameter int MAX_BINS    = MAX_BINS_DEF,
    parameter int PHASE_BITS  = PHASE_BITS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    hbcf_in_if.sink          i_in,
    hbcf_out_if.source       o_out,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [30:0] i_cfg_data
);

    localparam logic [PHASE_BITS-1:0] QUARTER = {2'b01, {(PHASE_BITS-2){1'b0}}};

    // One-hot sequencer states.
    typedef enum logic [18:0] {
        S_IDLE = 19'b0000000000000000001,
        S_ZZ   = 19'b0000000000000000010,
        S_T1   = 19'b0000000000000000100,
        S_T2   = 19'b0000000000000001000,
        S_SN   = 19'b0000000000000010000,
        S_MIX  = 19'b0000000000000100000,
        S_ACC  = 19'b0000000000001000000,
        S_MA   = 19'b0000000000010000000,
        S_MB   = 19'b0000000000100000000,
        S_MSUM = 19'b0000000001000000000,
        S_W0   = 19'b0000000010000000000,
        S_W1   = 19'b0000000100000000000,
        S_W2   = 19'b0000001000000000000,
        S_DIV  = 19'b0000010000000000000,
        S_MQ   = 19'b0000100000000000000,
        S_CEN  = 19'b0001000000000000000,
        S_HIS  = 19'b0010000000000000000,
        S_GM   = 19'b0100000000000000000,
        S_DRV  = 19'b1000000000000000000
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [12:0] r_skip;
    logic [15:0] r_step;
    logic [13:0] r_spb;
    logic [6:0]  r_bcnt;
    logic [30:0] r_bts;
    logic [30:0] r_off;
    logic [15:0] r_decay;
    logic [15:0] r_gain;

    // Shot state.
    logic [PHASE_BITS-1:0]  r_phase;
    logic [PHASE_BITS-1:0]  r_ph;
    logic [13:0]            r_sidx;
    logic [13:0]            r_fill;
    logic [6:0]             r_bidx;
    logic signed [39:0]     r_isum;
    logic signed [39:0]     r_qsum;
    logic [55:0]            r_mag;
    logic [63:0]            r_wsum;
    logic signed [33:0]     r_hist;
    logic signed [31:0]     r_drv;
    logic                   r_done;
    logic                   r_which;

    // Divider state.
    logic [4:0]  r_cnt;
    logic [55:0] r_rem;
    logic [29:0] r_dbits;
    logic [29:0] r_q;

    // Output register.
    logic               r_ovalid;
    logic signed [31:0] r_ocenter;
    logic signed [31:0] r_odrive;
    logic [1:0]         r_orail;

    // Datapath registers without reset.
    logic signed [66:0]            r_prod;
    logic [16:0]                   r_z2;
    logic [49:0]                   r_m;
    logic signed [SAMPLE_BITS-1:0] r_smp;
    logic signed [31:0]            r_cen;

    // Shared multiplier operands.
    logic signed [34:0] w_mul_a;
    logic signed [31:0] w_mul_b;

    logic                   w_accept;
    logic                   w_out_free;
    logic [PHASE_BITS-1:0]  w_pw;
    logic [1:0]             w_quad;
    logic [PHASE_BITS+4:0]  w_zf;
    logic [15:0]            w_z;
    logic [16:0]            w_s;
    logic signed [17:0]     w_trig;
    logic [39:0]            w_iabs;
    logic [39:0]            w_qabs;
    logic signed [39:0]     w_acc_in;
    logic signed [40:0]     w_acc_sum;
    logic signed [39:0]     w_acc_sat;
    logic [13:0]            w_spb;
    logic [6:0]             w_bins;
    logic [13:0]            w_nfill;
    logic [6:0]             w_nbidx;
    logic [49:0]            w_m;
    logic [63:0]            w_wnew;
    logic [56:0]            w_trial;
    logic                   w_ge;
    logic [36:0]            w_centroid;
    logic signed [38:0]     w_cdiff;
    logic signed [31:0]     w_center;
    logic signed [51:0]     w_hsum;
    logic signed [33:0]     w_hist;
    logic signed [51:0]     w_dsum;
    logic signed [31:0]     w_drive;
    logic [1:0]             w_rail;
    logic                   w_start;
    logic                   w_done_e;
    logic [PHASE_BITS-1:0]  w_ph_e;
    logic [13:0]            w_sidx_e;

    assign w_accept   = i_in.valid && (r_state == S_IDLE);
    assign w_out_free = !r_ovalid || o_out.ready;

    assign i_in.ready   = (r_state == S_IDLE);
    assign o_out.valid  = r_ovalid;
    assign o_out.center = r_ocenter;
    assign o_out.drive  = r_odrive;
    assign o_out.rail   = r_orail;

    // Effective shot state for the sample being taken.
    assign w_start  = i_in.shot_start;
    assign w_done_e = w_start ? 1'b0 : r_done;
    assign w_ph_e   = w_start ? '0 : r_phase;
    assign w_sidx_e = w_start ? '0 : r_sidx;

    // Phase to quarter-wave argument: cosine is the sine a quarter turn later, and odd
    // quadrants run the quarter wave backwards.
    always_comb begin
        w_pw   = r_ph + (r_which ? QUARTER : '0);
        w_quad = w_pw[PHASE_BITS-1:PHASE_BITS-2];
        w_zf   = {w_pw[PHASE_BITS-3:0], 7'b0} >> (PHASE_BITS - 10);
        w_z    = w_quad[0] ? (16'd32768 - {1'b0, w_zf[14:0]}) : {1'b0, w_zf[14:0]};
        w_s    = r_prod[31:15];
        w_trig = w_quad[1] ? -$signed({1'b0, w_s}) : $signed({1'b0, w_s});
    end

    // Magnitudes and clamped bin parameters.
    always_comb begin
        w_iabs = r_isum[39] ? (~r_isum + 40'd1) : r_isum;
        w_qabs = r_qsum[39] ? (~r_qsum + 40'd1) : r_qsum;

        if (r_spb == '0) begin
            w_spb = 14'd1;
        end else if (r_spb > SPB_LIMIT) begin
            w_spb = SPB_LIMIT;
        end else begin
            w_spb = r_spb;
        end

        if (r_bcnt == '0) begin
            w_bins = 7'd1;
        end else if (r_bcnt > 7'(MAX_BINS)) begin
            w_bins = 7'(MAX_BINS);
        end else begin
            w_bins = r_bcnt;
        end

        w_nfill = r_fill + 14'd1;
        w_nbidx = r_bidx + 7'd1;
    end

    // Saturating I or Q accumulate.
    always_comb begin
        w_acc_in  = r_which ? r_isum : r_qsum;
        w_acc_sum = 41'(w_acc_in) + 41'($signed(r_prod[31:0]));
        if (w_acc_sum > ACC_MAX) begin
            w_acc_sat = 40'(ACC_MAX);
        end else if (w_acc_sum < ACC_MIN) begin
            w_acc_sat = 40'(ACC_MIN);
        end else begin
            w_acc_sat = w_acc_sum[39:0];
        end
    end

    // Bin totals and one restoring divider step.
    always_comb begin
        w_m     = r_m + r_prod[49:0];
        w_wnew  = r_wsum + 64'({r_prod[31:0], 25'b0});
        w_trial = {r_rem, r_dbits[29]};
        w_ge    = (w_trial >= {1'b0, r_mag});
    end

    // Centroid, history and drive arithmetic after the shot.
    always_comb begin
        w_centroid = (r_mag == '0) ? '0 : r_prod[60:24];
        w_cdiff    = $signed({2'b0, w_centroid}) - $signed({8'b0, r_off});
        if (w_cdiff > I32_MAX) begin
            w_center = 32'(I32_MAX);
        end else if (w_cdiff < I32_MIN) begin
            w_center = 32'(I32_MIN);
        end else begin
            w_center = w_cdiff[31:0];
        end

        w_hsum = 52'($signed(r_prod[66:16])) + 52'(r_cen);
        if (w_hsum > HIST_MAX) begin
            w_hist = 34'(HIST_MAX);
        end else if (w_hsum < HIST_MIN) begin
            w_hist = 34'(HIST_MIN);
        end else begin
            w_hist = w_hsum[33:0];
        end

        w_dsum = 52'($signed(r_prod[66:16])) + 52'(r_drv);
        if (w_dsum > ONE_Q30) begin
            w_drive = 32'(ONE_Q30);
            w_rail  = RAIL_HIGH;
        end else if (w_dsum < -ONE_Q30) begin
            w_drive = 32'(-ONE_Q30);
            w_rail  = RAIL_LOW;
        end else begin
            w_drive = w_dsum[31:0];
            w_rail  = RAIL_NONE;
        end
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (r_state)
            S_ZZ: begin
                w_mul_a = $signed({19'b0, w_z});
                w_mul_b = $signed({16'b0, w_z});
            end
            S_T1: begin
                w_mul_a = $signed({18'b0, r_prod[31:15]});
                w_mul_b = $signed({20'b0, SIN_C5});
            end
            S_T2: begin
                w_mul_a = $signed({18'b0, r_z2});
                w_mul_b = $signed({17'b0, SIN_C3 - {3'b0, r_prod[26:15]}});
            end
            S_SN: begin
                w_mul_a = $signed({19'b0, w_z});
                w_mul_b = $signed({16'b0, SIN_C1 - {1'b0, r_prod[29:15]}});
            end
            S_MIX: begin
                w_mul_a = 35'(r_smp);
                w_mul_b = 32'(w_trig);
            end
            S_MA: begin
                w_mul_a = $signed({10'b0, w_iabs[39:15]});
                w_mul_b = $signed({7'b0, w_iabs[39:15]});
            end
            S_MB: begin
                w_mul_a = $signed({10'b0, w_qabs[39:15]});
                w_mul_b = $signed({7'b0, w_qabs[39:15]});
            end
            S_W0: begin
                w_mul_a = $signed({10'b0, r_m[24:0]});
                w_mul_b = $signed({25'b0, r_bidx});
            end
            S_W1: begin
                w_mul_a = $signed({10'b0, r_m[49:25]});
                w_mul_b = $signed({25'b0, r_bidx});
            end
            S_MQ: begin
                w_mul_a = $signed({5'b0, r_q});
                w_mul_b = $signed({1'b0, r_bts});
            end
            S_CEN: begin
                w_mul_a = 35'(r_hist);
                w_mul_b = $signed({16'b0, r_decay});
            end
            // The gain product is kept while the finished result waits for the slot.
            S_GM, S_DRV: begin
                w_mul_a = 35'(r_hist);
                w_mul_b = $signed({16'b0, r_gain});
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    // Datapath registers: the product register follows the multiplier every cycle.
    always_ff @(posedge i_clk) begin
        r_prod <= 67'(w_mul_a) * 67'(w_mul_b);
        if (r_state == S_T1) begin
            r_z2 <= r_prod[31:15];
        end
        if (r_state == S_MB) begin
            r_m <= r_prod[49:0];
        end else if (r_state == S_MSUM) begin
            r_m <= w_m;
        end
        if (w_accept) begin
            r_smp <= i_in.sample;
        end
        if (r_state == S_CEN) begin
            r_cen <= w_center;
        end
        if (r_state == S_DRV && w_out_free) begin
            r_ocenter <= r_cen;
            r_odrive  <= w_drive;
            r_orail   <= w_rail;
        end
    end

    // Sequencer, configuration and shot state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_skip   <= SKIP_RST;
            r_step   <= STEP_RST;
            r_spb    <= SPB_RST;
            r_bcnt   <= BINS_RST;
            r_bts    <= BTS_RST;
            r_off    <= OFFSET_RST;
            r_decay  <= DECAY_RST;
            r_gain   <= GAIN_RST;
            r_phase  <= '0;
            r_ph     <= '0;
            r_sidx   <= '0;
            r_fill   <= '0;
            r_bidx   <= '0;
            r_isum   <= '0;
            r_qsum   <= '0;
            r_mag    <= '0;
            r_wsum   <= '0;
            r_hist   <= '0;
            r_drv    <= '0;
            r_done   <= 1'b1;
            r_which  <= 1'b0;
            r_cnt    <= '0;
            r_rem    <= '0;
            r_dbits  <= '0;
            r_q      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_reg_idx'(i_cfg_idx))
                    REG_SKIP:   r_skip  <= i_cfg_data[12:0];
                    REG_STEP:   r_step  <= i_cfg_data[15:0];
                    REG_SPB:    r_spb   <= i_cfg_data[13:0];
                    REG_BINS:   r_bcnt  <= i_cfg_data[6:0];
                    REG_BTS:    r_bts   <= i_cfg_data;
                    REG_OFFSET: r_off   <= i_cfg_data;
                    REG_DECAY:  r_decay <= i_cfg_data[15:0];
                    REG_GAIN:   r_gain  <= i_cfg_data[15:0];
                    default:    r_skip  <= r_skip;
                endcase
            end

            // In the drive state the output register is refilled below instead.
            if (r_ovalid && o_out.ready && r_state != S_DRV) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (w_start) begin
                            r_fill <= '0;
                            r_bidx <= '0;
                            r_isum <= '0;
                            r_qsum <= '0;
                            r_mag  <= '0;
                            r_wsum <= '0;
                            r_done <= 1'b0;
                        end
                        if (!w_done_e) begin
                            r_ph    <= w_ph_e;
                            r_phase <= w_ph_e + PHASE_BITS'(r_step);
                            if (w_sidx_e < {1'b0, r_skip}) begin
                                r_sidx <= w_sidx_e + 14'd1;
                            end else begin
                                r_sidx  <= w_sidx_e;
                                r_which <= 1'b0;
                                r_state <= S_ZZ;
                            end
                        end
                    end
                end
                S_ZZ:  r_state <= S_T1;
                S_T1:  r_state <= S_T2;
                S_T2:  r_state <= S_SN;
                S_SN:  r_state <= S_MIX;
                S_MIX: r_state <= S_ACC;
                S_ACC: begin
                    if (r_which) begin
                        r_isum <= w_acc_sat;
                        if (w_nfill < w_spb) begin
                            r_fill  <= w_nfill;
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_MA;
                        end
                    end else begin
                        r_qsum  <= w_acc_sat;
                        r_which <= 1'b1;
                        r_state <= S_ZZ;
                    end
                end
                S_MA: r_state <= S_MB;
                S_MB: r_state <= S_MSUM;
                S_MSUM: begin
                    r_mag   <= r_mag + 56'(w_m);
                    r_state <= S_W0;
                end
                S_W0: r_state <= S_W1;
                S_W1: begin
                    r_wsum  <= r_wsum + 64'(r_prod[31:0]);
                    r_state <= S_W2;
                end
                S_W2: begin
                    // The bin closes here; the weighted sum is complete for this bin.
                    r_wsum <= w_wnew;
                    r_isum <= '0;
                    r_qsum <= '0;
                    r_fill <= '0;
                    r_bidx <= w_nbidx;
                    if (w_nbidx < w_bins) begin
                        r_state <= S_IDLE;
                    end else begin
                        // The quotient stays below 2^30, so the top of the dividend
                        // already lies below the divisor.
                        r_rem   <= w_wnew[61:6];
                        r_dbits <= {w_wnew[5:0], 24'b0};
                        r_q     <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem   <= w_ge ? 56'(w_trial - {1'b0, r_mag}) : w_trial[55:0];
                    r_q     <= {r_q[28:0], w_ge};
                    r_dbits <= {r_dbits[28:0], 1'b0};
                    r_cnt   <= r_cnt + 5'd1;
                    if (r_cnt == 5'd29) begin
                        r_state <= S_MQ;
                    end
                end
                S_MQ:  r_state <= S_CEN;
                S_CEN: r_state <= S_HIS;
                S_HIS: begin
                    r_hist  <= w_hist;
                    r_state <= S_GM;
                end
                S_GM: r_state <= S_DRV;
                S_DRV: begin
                    if (w_out_free) begin
                        r_drv    <= w_drive;
                        r_done   <= 1'b1;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== design/hbcf_checker.sv =====
// Port-level checker for the heterodyne bin centroid feedback core, with its bind.
`default_nettype none

module hbcf_checker
    import hbcf_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [31:0] i_out_drive,
    input wire logic [1:0]  i_out_rail
);

    // A result waiting for the receiver keeps its valid.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // Reset empties the output register.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result present after reset");

    // The drive never leaves plus or minus one.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ($signed(i_out_drive) <= 32'sd1073741824 &&
                         $signed(i_out_drive) >= -32'sd1073741824))
        else $error("drive out of range");

    // A high rail means the drive sits exactly at plus one.
    a_rail_hi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_rail == RAIL_HIGH |-> i_out_drive == 32'h4000_0000)
        else $error("high rail without clamped drive");

    // A low rail means the drive sits exactly at minus one.
    a_rail_lo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_rail == RAIL_LOW |-> i_out_drive == 32'hC000_0000)
        else $error("low rail without clamped drive");

endmodule

bind heterodyne_bin_centroid_feedback_core hbcf_checker u_hbcf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_drive (o_out.drive),
    .i_out_rail  (o_out.rail)
);

`default_nettype wire
